// ----- hdl/upd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the URL percent decoder: transaction types, codes and helper functions.
package upd_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int OUT_LEN_W       = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FORM_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT_LEN = 2'd1;

    localparam logic [CFG_DATA_W-1:0] MAX_OUT_LEN_RST = 16'hFFFF;

    localparam logic [7:0] CHR_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CHR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHR_SPACE = 8'h20;  // ' '

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 byte_valid;
        logic                 out_last;
        logic [OUT_LEN_W-1:0] out_length;
    } t_out;

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } t_esc;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    // Nibble value of a hex digit, either case
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b <= 8'h46) begin
            v = b - 8'h37;
        end else begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ----- hdl/url_percent_decoder_core.sv -----
`timescale 1ns / 1ps
// URL percent decoder core: one raw byte per transaction in, decoded bytes out.
// A result enters the output register as its input is taken, when the output is free.
// Throughput: one input per cycle while each gives at most one result and the output is taken;
//   extra results (a failed escape replays '%' and the held digit) or a stalled output fill the
//   three-entry pending queue; input ready stays low until it drains, one result per cycle while taken.
// Reset: synchronous, active low; clears escape state, count, queue and output valid, and
//   loads form_mode 0 and max_out_len 65535. No clearing pass.
module url_percent_decoder_core #(
    parameter int LENGTH_BITS = upd_pkg::LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  upd_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output upd_pkg::t_out                 o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [upd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [upd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Working width for limit arithmetic: wide enough for both the count and max_out_len
    localparam int LW = (LENGTH_BITS > upd_pkg::CFG_DATA_W) ? LENGTH_BITS
                                                             : upd_pkg::CFG_DATA_W;
    localparam logic [LW-1:0] CAP = LW'({LENGTH_BITS{1'b1}});

    // Configuration registers
    logic                          r_form_mode;
    logic [upd_pkg::CFG_DATA_W-1:0] r_max_len;

    // Decode state
    upd_pkg::t_esc          r_esc, n_esc;
    logic [7:0]             r_held, n_held;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;

    // Output register and pending queue (results of one transaction that wait for the output)
    logic          r_out_valid, n_out_valid;
    upd_pkg::t_out r_out, n_out;
    upd_pkg::t_out r_pend [3];
    upd_pkg::t_out n_pend [3];
    logic [1:0]    r_pcnt, n_pcnt;

    // Results of the transaction being accepted
    upd_pkg::t_out new_res [3];
    logic [1:0]    new_m;

    logic in_acc;
    logic out_free;

    assign o_cfg_ready = 1'b1;
    // Input is taken only when no extra results are queued; the queue acts as the skid stage
    assign o_in_ready  = (r_pcnt == 2'd0);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------
    // Decode one byte: up to three candidate bytes, then apply the limit
    // ---------------------------------------------------------------
    always_comb begin
        logic [7:0]    b;
        logic          last;
        logic          hex;
        logic          p_emit;
        logic [7:0]    p_byte;
        logic          p_esc;
        logic [7:0]    cand [3];
        logic [1:0]    k;
        logic [LW-1:0] limit;
        logic [LW-1:0] cnt_w;
        logic [LW-1:0] avail;
        logic [LW-1:0] len_j;
        logic [1:0]    n;

        b      = i_in.in_byte;
        last   = i_in.in_last;
        hex    = upd_pkg::is_hex(b);

        // Plain handling of the current byte
        p_esc  = (b == upd_pkg::CHR_PCT) && !last;
        p_emit = !p_esc;
        p_byte = (r_form_mode && b == upd_pkg::CHR_PLUS) ? upd_pkg::CHR_SPACE : b;

        cand[0] = p_byte;
        cand[1] = p_byte;
        cand[2] = p_byte;
        k       = {1'b0, p_emit};
        n_esc   = p_esc ? upd_pkg::ESC_PCT : upd_pkg::ESC_NONE;
        n_held  = r_held;

        case (r_esc)
            upd_pkg::ESC_NONE: begin
                cand[0] = p_byte;
                k       = {1'b0, p_emit};
            end
            upd_pkg::ESC_PCT: begin
                if (hex && !last) begin
                    n_held = b;
                    n_esc  = upd_pkg::ESC_DIGIT;
                    k      = 2'd0;
                end else begin
                    // escape failed: replay '%', then the byte as usual
                    cand[0] = upd_pkg::CHR_PCT;
                    cand[1] = p_byte;
                    k       = 2'd1 + {1'b0, p_emit};
                end
            end
            upd_pkg::ESC_DIGIT: begin
                if (hex) begin
                    cand[0] = {upd_pkg::hex_val(r_held), upd_pkg::hex_val(b)};
                    n_esc   = upd_pkg::ESC_NONE;
                    k       = 2'd1;
                end else begin
                    cand[0] = upd_pkg::CHR_PCT;
                    cand[1] = r_held;
                    cand[2] = p_byte;
                    k       = 2'd2 + {1'b0, p_emit};
                end
            end
            default: begin
                k = 2'd0;
            end
        endcase

        if (last) begin
            n_esc = upd_pkg::ESC_NONE;
        end

        // Length limit: bytes past it are dropped
        limit = (LW'(r_max_len) < CAP) ? LW'(r_max_len) : CAP;
        cnt_w = LW'(r_cnt);
        avail = (cnt_w >= limit) ? '0 : (limit - cnt_w);
        n     = (avail < LW'(k)) ? avail[1:0] : k;

        for (int j = 0; j < 3; j++) begin
            len_j = cnt_w + LW'(j + 1);
            new_res[j].out_byte   = cand[j];
            new_res[j].byte_valid = 1'b1;
            new_res[j].out_last   = last && (2'(j + 1) == n);
            new_res[j].out_length = len_j[upd_pkg::OUT_LEN_W-1:0];
        end

        // Last byte with nothing emitted: one empty closing result
        if (n == 2'd0) begin
            new_res[0].out_byte   = 8'h00;
            new_res[0].byte_valid = 1'b0;
            new_res[0].out_last   = 1'b1;
            new_res[0].out_length = cnt_w[upd_pkg::OUT_LEN_W-1:0];
            new_m                 = {1'b0, last};
        end else begin
            new_m = n;
        end

        n_cnt = last ? '0 : (r_cnt + LENGTH_BITS'(n));
    end

    // ---------------------------------------------------------------
    // Output register and pending queue
    // ---------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pend      = r_pend;
        n_pcnt      = r_pcnt;

        if (r_pcnt != 2'd0) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = r_pend[0];
                n_pend[0]   = r_pend[1];
                n_pend[1]   = r_pend[2];
                n_pcnt      = r_pcnt - 2'd1;
            end
        end else if (in_acc) begin
            if (out_free) begin
                n_out_valid = (new_m != 2'd0);
                n_out       = new_res[0];
                n_pend[0]   = new_res[1];
                n_pend[1]   = new_res[2];
                n_pcnt      = (new_m != 2'd0) ? (new_m - 2'd1) : 2'd0;
            end else begin
                n_pend = new_res;
                n_pcnt = new_m;
            end
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form_mode <= 1'b0;
            r_max_len   <= upd_pkg::MAX_OUT_LEN_RST;
            r_esc       <= upd_pkg::ESC_NONE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_pcnt      <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == upd_pkg::CFG_FORM_MODE) begin
                    r_form_mode <= i_cfg_data[0];
                end else if (i_cfg_index == upd_pkg::CFG_MAX_OUT_LEN) begin
                    r_max_len <= i_cfg_data;
                end
            end
            if (in_acc) begin
                r_esc <= n_esc;
                r_cnt <= n_cnt;
            end
            r_out_valid <= n_out_valid;
            r_pcnt      <= n_pcnt;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_held <= n_held;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

endmodule

// ----- hdl/upd_checker.sv -----
`timescale 1ns / 1ps
// Port checker for the URL percent decoder core, with its bind.
module upd_port_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input upd_pkg::t_out o_out
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Reset empties the output
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An empty result only closes a string, with a zero byte
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.byte_valid |-> o_out.out_last && o_out.out_byte == 8'h00)
        else $error("empty result not closing a string");

    // Every decoded byte counts, so its length is never zero
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.byte_valid |-> o_out.out_length != '0)
        else $error("decoded byte with zero length");

    // Within a string the length climbs by one per byte handed over
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.byte_valid && !o_out.out_last
        ##1 o_out_valid && o_out.byte_valid
        |-> o_out.out_length == $past(o_out.out_length) + 16'd1)
        else $error("length did not step by one");

endmodule

bind url_percent_decoder_core upd_port_checker u_upd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ----- tb/upd_checker.sv -----
`timescale 1ns / 1ps
// Checker for the URL percent decoder: tracks the channels, predicts decoded bytes, compares.
module upd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  upd_pkg::t_in                   i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  upd_pkg::t_out                  i_out,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [upd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [upd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_end,
    output int                             o_fail_count,
    output int                             o_pending
);

    // Own copy of the registers and the decoder state
    logic                          form_on;
    logic [15:0]                   len_cap;
    upd_pkg::t_esc                 esc;
    logic [7:0]                    first_digit;
    logic [upd_pkg::OUT_LEN_W-1:0] run_len;

    upd_pkg::t_out expected_chars[$];
    upd_pkg::t_out staged;
    bit            staged_ok;
    upd_pkg::t_out want;
    bit            end_seen;
    int            mismatches;

    initial begin
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        end_seen     = 1'b0;
        staged_ok    = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        o_fail_count = mismatches;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic bit is_hex_char(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c >= 8'h30 && c <= 8'h39) || (folded >= 8'h61 && folded <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c <= 8'h39) begin
            return c[3:0];
        end
        return folded[3:0] + 4'd9;
    endfunction

    // One decoded byte; held back one step so the string end can mark it
    task automatic push_char(input logic [7:0] c);
        if (run_len >= len_cap) begin
            return;
        end
        run_len = run_len + 1'b1;
        if (staged_ok) begin
            expected_chars.push_back(staged);
        end
        staged.out_byte   = c;
        staged.byte_valid = 1'b1;
        staged.out_last   = 1'b0;
        staged.out_length = run_len;
        staged_ok         = 1'b1;
    endtask

    task automatic take_plain(input logic [7:0] c, input logic last);
        if (c == upd_pkg::CHR_PCT && !last) begin
            esc = upd_pkg::ESC_PCT;
        end else if (form_on && c == upd_pkg::CHR_PLUS) begin
            push_char(upd_pkg::CHR_SPACE);
        end else begin
            push_char(c);
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic last);
        upd_pkg::t_esc prev;
        prev = esc;
        esc  = upd_pkg::ESC_NONE;
        case (prev)
            upd_pkg::ESC_PCT: begin
                if (is_hex_char(c) && !last) begin
                    first_digit = c;
                    esc         = upd_pkg::ESC_DIGIT;
                end else begin
                    push_char(upd_pkg::CHR_PCT);
                    take_plain(c, last);
                end
            end
            upd_pkg::ESC_DIGIT: begin
                if (is_hex_char(c)) begin
                    push_char({nibble_of(first_digit), nibble_of(c)});
                end else begin
                    push_char(upd_pkg::CHR_PCT);
                    push_char(first_digit);
                    take_plain(c, last);
                end
            end
            default: begin
                take_plain(c, last);
            end
        endcase
        if (last) begin
            if (staged_ok) begin
                staged.out_last = 1'b1;
            end else begin
                staged.out_byte   = 8'h00;
                staged.byte_valid = 1'b0;
                staged.out_last   = 1'b1;
                staged.out_length = run_len;
                staged_ok         = 1'b1;
            end
            run_len = '0;
            esc     = upd_pkg::ESC_NONE;
        end
        if (staged_ok) begin
            expected_chars.push_back(staged);
            staged_ok = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            form_on     = 1'b0;
            len_cap     = upd_pkg::MAX_OUT_LEN_RST;
            esc         = upd_pkg::ESC_NONE;
            first_digit = 8'h00;
            run_len     = '0;
            staged_ok   = 1'b0;
            expected_chars.delete();
        end else begin
            // Results first: nothing accepted at this edge can already be out
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result byte=%02h bv=%0b last=%0b len=%0d",
                        i_out.out_byte, i_out.byte_valid, i_out.out_last, i_out.out_length));
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out.out_byte !== want.out_byte || i_out.byte_valid !== want.byte_valid ||
                        i_out.out_last !== want.out_last ||
                        i_out.out_length !== want.out_length) begin
                        flag_mismatch($sformatf(
                            "got byte=%02h bv=%0b last=%0b len=%0d, want %02h %0b %0b %0d",
                            i_out.out_byte, i_out.byte_valid, i_out.out_last, i_out.out_length,
                            want.out_byte, want.byte_valid, want.out_last, want.out_length));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in.in_byte, i_in.in_last);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    upd_pkg::CFG_FORM_MODE:   form_on = i_cfg_data[0];
                    upd_pkg::CFG_MAX_OUT_LEN: len_cap = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (expected_chars.size() != 0) begin
                    flag_mismatch($sformatf("%0d expected results never arrived",
                        expected_chars.size()));
                end
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the URL percent decoder testbench: clock, reset, stimulus and verdict.
module testbench;

    // Clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Block inputs, all known from time zero
    logic                           in_valid  = 1'b0;
    upd_pkg::t_in                   in_pay    = '0;
    logic                           out_ready = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [upd_pkg::CFG_IDX_W-1:0]  cfg_index = upd_pkg::CFG_FORM_MODE;
    logic [upd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           end_flag  = 1'b0;

    // Block outputs
    logic          o_in_ready;
    logic          o_out_valid;
    upd_pkg::t_out o_out;
    logic          o_cfg_ready;

    // Checker feedback
    int fail_count;
    int pending;

    // Idling controls: odds are 1-in-N per input byte or per result-side clock, 0 turns a side's idling off;
    // calm switches all idling off for the closing stretch of the run
    int unsigned gap_odds   = 0;
    int unsigned stall_odds = 0;
    bit          calm       = 1'b0;
    int unsigned sink_stall = 0;
    int          sent_items = 0;

    url_percent_decoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_pay),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    upd_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (in_pay),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out        (o_out),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_end        (end_flag),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: ready drops in random bursts. Each signal gets at most one
    // nonblocking write per edge so the order of statements cannot matter.
    always @(posedge i_clk) begin
        if (calm || stall_odds == 0) begin
            out_ready  <= 1'b1;
            sink_stall <= 0;
        end else if (sink_stall != 0) begin
            out_ready  <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if ($urandom_range(1, stall_odds) == 1) begin
            out_ready  <= 1'b0;
            sink_stall <= $urandom_range(0, 16);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // One raw byte as an input transaction. Valid is left high on return so
    // back-to-back bytes see no bubble; a gap burst lowers it first.
    task automatic put_byte(input logic [7:0] b, input logic last);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_pay   <= '{in_byte: b, in_last: last};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    // Whole string from text, last flag on its final character
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Drop valid and wait for every expected result to drain. Polled on the
    // falling edge so the checker's count from the rising edge is settled;
    // the trailing cycles cover work still in flight after a '%' with no result.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Both registers, back to back; valid held across the pair then dropped once
    task automatic set_config(input logic form, input logic [15:0] cap);
        cfg_valid <= 1'b1;
        cfg_index <= upd_pkg::CFG_FORM_MODE;
        cfg_data  <= {15'd0, form};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_index <= upd_pkg::CFG_MAX_OUT_LEN;
        cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_hex();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'h30 + v[7:0];
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v[7:0] - 8'd10;
    endfunction

    // Random string: mostly good escapes and plain bytes, with broken and
    // cut escapes mixed in so the replay paths are hit often
    task automatic send_random_string();
        logic [7:0]  seq[$];
        int unsigned tokens;
        int unsigned r;
        tokens = $urandom_range(1, 5);
        for (int t = 0; t < tokens; t++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                seq.push_back(upd_pkg::CHR_PCT);
                seq.push_back(pick_hex());
                seq.push_back(pick_hex());
            end else if (r < 45) begin
                seq.push_back(upd_pkg::CHR_PLUS);
            end else if (r < 52) begin
                seq.push_back(upd_pkg::CHR_PCT);
                seq.push_back(pick_hex());
                seq.push_back(8'($urandom_range(0, 255)));
            end else if (r < 58) begin
                seq.push_back(upd_pkg::CHR_PCT);
                seq.push_back(8'($urandom_range(0, 255)));
            end else if (r < 62) begin
                seq.push_back(upd_pkg::CHR_PCT);
            end else if (r < 66) begin
                seq.push_back(upd_pkg::CHR_PCT);
                seq.push_back(pick_hex());
            end else if (r < 72) begin
                seq.push_back(pick_hex());
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < seq.size(); i++) begin
            put_byte(seq[i], i == seq.size() - 1);
        end
    endtask

    // Stimulus
    initial begin
        logic [15:0] cap;
        int          strings;
        int          waited;

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the reset settings written explicitly
        set_config(1'b0, 16'hFFFF);
        send_text("%41%6a");      // decimal and lowercase hex digits
        send_text("%zz");         // '%' then a non-hex byte
        send_text("%4g");         // second digit not hex: three results
        send_text("%");           // lone '%' as the last byte
        send_text("a%");          // escape cut by the string end
        send_text("%4");          // escape cut after one digit
        send_text("%%41");        // failed escape restarting a new one
        send_text("+");           // plus kept outside form mode
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        settle();
        set_config(1'b1, 16'd2);
        send_text("+a+b");        // space from plus, then bytes dropped at the limit
        settle();
        set_config(1'b0, 16'd0);
        send_text("x%4");         // nothing emitted: empty closing result
        settle();

        // Random phases: fresh settings and idling mix, then a few strings
        while (sent_items < 220) begin
            case ($urandom_range(0, 7))
                0:       cap = 16'd0;
                1:       cap = 16'd1;
                2:       cap = 16'($urandom_range(2, 6));
                3, 4:    cap = 16'hFFFF;
                5:       cap = 16'($urandom_range(7, 40));
                default: cap = 16'($urandom_range(0, 65535));
            endcase
            set_config(1'($urandom_range(0, 1)), cap);
            case ($urandom_range(0, 3))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 8;
            endcase
            case ($urandom_range(0, 3))
                0:       stall_odds = 0;
                1:       stall_odds = 3;
                default: stall_odds = 8;
            endcase
            strings = $urandom_range(3, 6);
            for (int s = 0; s < strings; s++) begin
                if (sent_items >= 180) begin
                    calm = 1'b1;
                end
                send_random_string();
            end
            settle();
        end

        // Drain with a bound, let the pipeline empty, then have the checker
        // account for anything still outstanding
        in_valid <= 1'b0;
        @(negedge i_clk);
        for (waited = 0; waited < 20000 && pending != 0; waited++) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        end_flag <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/upd_pkg.sv
hdl/url_percent_decoder_core.sv
hdl/upd_checker.sv
tb/upd_checker.sv
tb/testbench.sv
